// ===== hw/rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared coordinate width, the default image size and the sequencer state type.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_W        = 6;
    localparam int IMAGE_SIZE_DEF = 64;

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_RUN   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_lr_state;

endpackage

// ===== hw/rtl/line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer unit
// Takes two end points and emits the pixels of the line inside the image, last one marked.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall   | start_x, start_y, end_x, end_y
//  out     | output    | o_out_valid / i_out_stall | pixel_x, pixel_y, last_pixel
//
// A line is handled in order: accept the word, set up the step terms, walk
// the positions along the major axis (at most 64) and flush the final pixel.
// The error-term adder and its correction set the pace of one position per
// cycle unless a stall holds the sequencer. Reset (i_rst_n low, synchronous)
// returns the sequencer to idle and empties the output register. A stall on
// the output holds the sequencer whenever a new pixel must be handed on.
// ----------------------------------------------------------------------------
module line_rasterizer_unit #(
    parameter int IMAGE_SIZE = lr_pkg::IMAGE_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [lr_pkg::COORD_W-1:0] i_start_x,
    input  logic [lr_pkg::COORD_W-1:0] i_start_y,
    input  logic [lr_pkg::COORD_W-1:0] i_end_x,
    input  logic [lr_pkg::COORD_W-1:0] i_end_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lr_pkg::COORD_W-1:0] o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0] o_pixel_y,
    output logic                       o_last_pixel
);
    import lr_pkg::*;

    localparam logic [COORD_W:0] L_SIZE = (COORD_W+1)'(IMAGE_SIZE);

    t_lr_state r_state, n_state;

    // Captured end points.
    logic [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1;

    // Step terms: span a, signed step b, error term r, coordinates.
    logic               r_step_y;
    logic [COORD_W-1:0] r_hi, r_t, r_c, r_a;
    logic [COORD_W:0]   r_b, r_r;
    logic [COORD_W-1:0] n_hi, n_t, n_c, n_a;
    logic [COORD_W:0]   n_b, n_r;
    logic               n_step_y;

    // Pixel waiting to learn whether it is the last one.
    logic               r_pend_valid, n_pend_valid;
    logic [COORD_W-1:0] r_pend_x, r_pend_y, n_pend_x, n_pend_y;

    // Output register.
    logic               r_out_valid, n_out_valid, r_last, n_last;
    logic [COORD_W-1:0] r_px, r_py, n_px, n_py;

    // Setup terms.
    logic signed [COORD_W:0] w_dx, w_dy;
    logic [COORD_W-1:0]      w_adx, w_ady;
    logic                    w_steep;

    // Error-term unit.
    logic signed [COORD_W+3:0] w_sum, w_two_a, w_two_b;
    logic [COORD_W:0]          w_r_next;
    logic [COORD_W-1:0]        w_c_next;

    logic               w_out_free, w_in_range;
    logic [COORD_W-1:0] w_cur_x, w_cur_y;

    always_comb begin
        w_dx    = $signed({1'b0, r_x1}) - $signed({1'b0, r_x0});
        w_dy    = $signed({1'b0, r_y1}) - $signed({1'b0, r_y0});
        w_adx   = COORD_W'(w_dx[COORD_W] ? -w_dx : w_dx);
        w_ady   = COORD_W'(w_dy[COORD_W] ? -w_dy : w_dy);
        w_steep = (w_dx == '0) || (w_ady > w_adx);
    end

    // The error term holds 2*b*k + a - 2*a*q in the range [0, 2a). Since
    // |b| <= a, one correction per step brings it back into range.
    always_comb begin
        w_two_b = {{2{r_b[COORD_W]}}, r_b, 1'b0};
        w_two_a = {3'b000, r_a, 1'b0};
        w_sum   = $signed({3'b000, r_r}) + w_two_b;
        if (w_sum >= w_two_a) begin
            w_r_next = (COORD_W+1)'(w_sum - w_two_a);
            w_c_next = r_c + 1'b1;
        end else if (w_sum < 0) begin
            w_r_next = (COORD_W+1)'(w_sum + w_two_a);
            w_c_next = r_c - 1'b1;
        end else begin
            w_r_next = (COORD_W+1)'(w_sum);
            w_c_next = r_c;
        end
    end

    always_comb begin
        w_cur_x    = r_step_y ? r_c : r_t;
        w_cur_y    = r_step_y ? r_t : r_c;
        w_in_range = ({1'b0, w_cur_x} < L_SIZE) && ({1'b0, w_cur_y} < L_SIZE);
        w_out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state      = r_state;
        n_step_y     = r_step_y;
        n_hi         = r_hi;
        n_t          = r_t;
        n_c          = r_c;
        n_a          = r_a;
        n_b          = r_b;
        n_r          = r_r;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_out_valid  = r_out_valid && i_out_stall;
        n_px         = r_px;
        n_py         = r_py;
        n_last       = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_step_y     = w_steep;
                n_pend_valid = 1'b0;
                if (w_steep) begin
                    n_t = (r_y0 <= r_y1) ? r_y0 : r_y1;
                    n_hi = (r_y0 <= r_y1) ? r_y1 : r_y0;
                    n_c = (r_y0 <= r_y1) ? r_x0 : r_x1;
                    n_a = w_ady;
                    n_b = w_dy[COORD_W] ? -w_dx : w_dx;
                end else begin
                    n_t = (r_x0 <= r_x1) ? r_x0 : r_x1;
                    n_hi = (r_x0 <= r_x1) ? r_x1 : r_x0;
                    n_c = (r_x0 <= r_x1) ? r_y0 : r_y1;
                    n_a = w_adx;
                    n_b = w_dx[COORD_W] ? -w_dy : w_dy;
                end
                n_r     = {1'b0, n_a};
                n_state = S_RUN;
            end
            S_RUN: begin
                // Hold only when a pending pixel must move to a busy output.
                if (!(w_in_range && r_pend_valid && !w_out_free)) begin
                    if (w_in_range) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_px        = r_pend_x;
                            n_py        = r_pend_y;
                            n_last      = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_x     = w_cur_x;
                        n_pend_y     = w_cur_y;
                    end
                    if (r_t == r_hi) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_t = r_t + 1'b1;
                        n_r = w_r_next;
                        n_c = w_c_next;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_px         = r_pend_x;
                    n_py         = r_pend_y;
                    n_last       = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_x0 <= i_start_x;
            r_y0 <= i_start_y;
            r_x1 <= i_end_x;
            r_y1 <= i_end_y;
        end
        r_step_y <= n_step_y;
        r_hi     <= n_hi;
        r_t      <= n_t;
        r_c      <= n_c;
        r_a      <= n_a;
        r_b      <= n_b;
        r_r      <= n_r;
        r_pend_x <= n_pend_x;
        r_pend_y <= n_pend_y;
        r_px     <= n_px;
        r_py     <= n_py;
        r_last   <= n_last;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_last;

endmodule
